[rtl/free_list_node_allocator_assert.svh]
// Assertion macros shared by the checkers of the free list node allocator.
// Each macro expects signals clk and arst_n in the scope where it is used.
`ifndef FREE_LIST_NODE_ALLOCATOR_ASSERT_SVH
`define FREE_LIST_NODE_ALLOCATOR_ASSERT_SVH

// same-cycle implication, disabled during reset
`define FLA_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled during reset
`define FLA_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[rtl/fla_pkg.sv]
// Shared types of the free list node allocator: function codes, command and status
// words between controller and datapath, and their select codes. No dependencies.
package fla_pkg;

	typedef enum logic [2:0] {
		FN_ALLOC = 3'd0,
		FN_FREE  = 3'd1,
		FN_WRITE = 3'd2,
		FN_READ  = 3'd3,
		FN_TEST  = 3'd4
	} fla_func_t;

	typedef enum logic [2:0] {
		X_HOLD = 3'd0,
		X_HEAD = 3'd1,
		X_ADDR = 3'd2,
		X_NEXT = 3'd3,
		X_INC  = 3'd4
	} fla_xsel_t;

	typedef enum logic [1:0] {
		C_HOLD = 2'd0,
		C_ZERO = 2'd1,
		C_ONE  = 2'd2,
		C_INC  = 2'd3
	} fla_csel_t;

	typedef enum logic [1:0] {
		LW_INIT   = 2'd0,
		LW_NIL    = 2'd1,
		LW_TAIL   = 2'd2,
		LW_SPLICE = 2'd3
	} fla_lwsel_t;

	typedef struct packed {
		logic       accept;
		fla_xsel_t  xsel;
		fla_csel_t  csel;
		logic       link_rd_head;
		logic       link_we;
		fla_lwsel_t link_wsel;
		logic       key_we;
		logic       data_we;
		logic       data_zero;
		logic       alloc_take;
		logic       set_tail;
		logic       splice;
		logic       set_oos;
		logic       set_found;
		logic       set_rval;
		logic       set_free;
		logic       load_out;
	} fla_cmd_t;

	typedef struct packed {
		logic addr_ok;
		logic head_null;
		logic x_null;
		logic x_hit;
		logic nx_null;
		logic key_hit;
		logic cnt_full;
		logic init_last;
		logic in_group;
		logic out_free;
	} fla_status_t;

endpackage

[rtl/free_list_node_allocator.sv]
// Top level of the free list node allocator: joins controller and datapath.
// Uses fla_pkg, fla_ctrl, fla_datapath.
//
//   channel  valid      stall      word
//   input    in_valid   in_stall   func addr key value last
//   output   out_valid  out_stall  start_addr read_value found is_free free_count
//                                  out_of_space
//
// After reset a clearing pass sets up the links and zeroes data.
// Allocate takes the free head; on an empty free list it reports out of space. Unknown
// codes go straight to the result. Test walks the free list until it meets the address;
// free walks like test, then follows its chain and splices it onto the free list. Write
// and read walk the chain from the address until the key matches.
// One item is in work at a time; a finished word waits in the output register meanwhile.
module free_list_node_allocator import fla_pkg::*; #(
	parameter int NODES = 64,
	parameter int KEY_BITS = 8,
	parameter int DATA_BITS = 32,
	localparam int AW = $clog2(NODES),
	localparam int CW = $clog2(NODES + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [2:0]                  func,
	input  logic [AW-1:0]               addr,
	input  logic [KEY_BITS-1:0]         key,
	input  logic signed [DATA_BITS-1:0] value,
	input  logic                        last,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [AW-1:0]               start_addr,
	output logic signed [DATA_BITS-1:0] read_value,
	output logic                        found,
	output logic                        is_free,
	output logic [CW-1:0]               free_count,
	output logic                        out_of_space
);

	fla_cmd_t    cmd;
	fla_status_t st;

	fla_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.func     (func),
		.st       (st),
		.cmd      (cmd)
	);

	fla_datapath #(
		.NODES     (NODES),
		.KEY_BITS  (KEY_BITS),
		.DATA_BITS (DATA_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.st           (st),
		.addr         (addr),
		.key          (key),
		.value        (value),
		.last         (last),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.start_addr   (start_addr),
		.read_value   (read_value),
		.found        (found),
		.is_free      (is_free),
		.free_count   (free_count),
		.out_of_space (out_of_space)
	);

endmodule

[rtl/fla_ram.sv]
// Generic single write port RAM with one registered read port.
// Read during write to the same address returns the old word. No dependencies.
module fla_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/fla_datapath.sv]
// Datapath of the free list node allocator: node memories, list registers,
// walk pointer and counter, result staging and output register. Uses fla_pkg, fla_ram.
module fla_datapath import fla_pkg::*; #(
	parameter int NODES = 64,
	parameter int KEY_BITS = 8,
	parameter int DATA_BITS = 32,
	localparam int AW = $clog2(NODES),
	localparam int PW = AW + 1,
	localparam int CW = $clog2(NODES + 1)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  fla_cmd_t                    cmd,
	output fla_status_t                 st,
	input  logic [AW-1:0]               addr,
	input  logic [KEY_BITS-1:0]         key,
	input  logic signed [DATA_BITS-1:0] value,
	input  logic                        last,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [AW-1:0]               start_addr,
	output logic signed [DATA_BITS-1:0] read_value,
	output logic                        found,
	output logic                        is_free,
	output logic [CW-1:0]               free_count,
	output logic                        out_of_space
);

	localparam logic [PW-1:0] NIL = PW'(NODES);
	localparam logic [CW-1:0] FULL = CW'(NODES);

	logic [AW-1:0]               addr_q;
	logic [KEY_BITS-1:0]         key_q;
	logic signed [DATA_BITS-1:0] value_q;
	logic                        last_q;
	logic [PW-1:0]               free_head_q;
	logic [CW-1:0]               free_nodes_q;
	logic [AW-1:0]               group_start_q;
	logic [AW-1:0]               group_tail_q;
	logic                        in_group_q;
	logic [PW-1:0]               x_q;
	logic [CW-1:0]               cnt_q;
	logic                        out_valid_q;

	logic [AW-1:0]               res_start_q;
	logic signed [DATA_BITS-1:0] res_rval_q;
	logic                        res_found_q;
	logic                        res_free_q;
	logic                        res_oos_q;

	logic [AW-1:0]               start_q;
	logic signed [DATA_BITS-1:0] rval_q;
	logic                        found_q;
	logic                        free_q;
	logic                        oos_q;
	logic [CW-1:0]               count_q;

	logic [AW-1:0]        link_waddr;
	logic [PW-1:0]        link_wdata;
	logic [AW-1:0]        link_raddr;
	logic [PW-1:0]        link_rdata;
	logic [KEY_BITS-1:0]  key_rdata;
	logic [DATA_BITS-1:0] data_wdata;
	logic [DATA_BITS-1:0] data_rdata;
	logic [PW-1:0]        nx;
	logic [PW-1:0]        x_d;
	logic [CW-1:0]        cnt_d;
	logic [CW:0]          sum;
	logic [CW-1:0]        sum_cap;

	assign nx = (link_rdata >= NIL) ? NIL : link_rdata;
	assign link_raddr = cmd.link_rd_head ? free_head_q[AW-1:0] : x_q[AW-1:0];
	assign data_wdata = cmd.data_zero ? '0 : value_q;
	assign sum = {1'b0, free_nodes_q} + {1'b0, cnt_q};
	assign sum_cap = (sum > {1'b0, FULL}) ? FULL : sum[CW-1:0];

	always_comb begin
		unique case (cmd.link_wsel)
			LW_INIT: begin
				link_waddr = x_q[AW-1:0];
				link_wdata = x_q + PW'(1);
			end
			LW_NIL: begin
				link_waddr = free_head_q[AW-1:0];
				link_wdata = NIL;
			end
			LW_TAIL: begin
				link_waddr = group_tail_q;
				link_wdata = x_q;
			end
			LW_SPLICE: begin
				link_waddr = x_q[AW-1:0];
				link_wdata = free_head_q;
			end
		endcase
	end

	always_comb begin
		unique case (cmd.xsel)
			X_HOLD: x_d = x_q;
			X_HEAD: x_d = free_head_q;
			X_ADDR: x_d = {1'b0, (cmd.accept ? addr : addr_q)};
			X_NEXT: x_d = nx;
			X_INC:  x_d = x_q + PW'(1);
			default: x_d = x_q;
		endcase
		unique case (cmd.csel)
			C_HOLD: cnt_d = cnt_q;
			C_ZERO: cnt_d = '0;
			C_ONE:  cnt_d = CW'(1);
			C_INC:  cnt_d = cnt_q + CW'(1);
		endcase
	end

	fla_ram #(.WIDTH(PW), .DEPTH(NODES)) u_link (
		.clk   (clk),
		.we    (cmd.link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.raddr (link_raddr),
		.rdata (link_rdata)
	);

	fla_ram #(.WIDTH(KEY_BITS), .DEPTH(NODES)) u_key (
		.clk   (clk),
		.we    (cmd.key_we),
		.waddr (free_head_q[AW-1:0]),
		.wdata (key_q),
		.raddr (x_q[AW-1:0]),
		.rdata (key_rdata)
	);

	fla_ram #(.WIDTH(DATA_BITS), .DEPTH(NODES)) u_data (
		.clk   (clk),
		.we    (cmd.data_we),
		.waddr (x_q[AW-1:0]),
		.wdata (data_wdata),
		.raddr (x_q[AW-1:0]),
		.rdata (data_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q   <= '0;
			free_nodes_q  <= FULL;
			group_start_q <= '0;
			group_tail_q  <= '0;
			in_group_q    <= 1'b0;
			x_q           <= '0;
			cnt_q         <= '0;
			out_valid_q   <= 1'b0;
		end else begin
			x_q   <= x_d;
			cnt_q <= cnt_d;
			if (cmd.alloc_take) begin
				free_head_q <= nx;
				if (free_nodes_q != '0) begin
					free_nodes_q <= free_nodes_q - CW'(1);
				end
				if (!in_group_q) begin
					group_start_q <= free_head_q[AW-1:0];
				end
				in_group_q <= !last_q;
			end
			if (cmd.splice) begin
				free_head_q  <= {1'b0, addr_q};
				free_nodes_q <= sum_cap;
			end
			if (cmd.set_tail) begin
				group_tail_q <= x_q[AW-1:0];
			end
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			addr_q      <= addr;
			key_q       <= key;
			value_q     <= value;
			last_q      <= last;
			res_start_q <= '0;
			res_rval_q  <= '0;
			res_found_q <= 1'b0;
			res_free_q  <= 1'b0;
			res_oos_q   <= 1'b0;
		end
		if (cmd.alloc_take && last_q) begin
			res_start_q <= in_group_q ? group_start_q : free_head_q[AW-1:0];
		end
		if (cmd.set_rval) begin
			res_rval_q <= data_rdata;
		end
		if (cmd.set_found) begin
			res_found_q <= 1'b1;
		end
		if (cmd.set_free) begin
			res_free_q <= 1'b1;
		end
		if (cmd.set_oos) begin
			res_oos_q <= 1'b1;
		end
		if (cmd.load_out) begin
			start_q <= res_start_q;
			rval_q  <= res_rval_q;
			found_q <= res_found_q;
			free_q  <= res_free_q;
			oos_q   <= res_oos_q;
			count_q <= free_nodes_q;
		end
	end

	assign st.addr_ok   = {1'b0, addr_q} < NIL;
	assign st.head_null = free_head_q >= NIL;
	assign st.x_null    = x_q >= NIL;
	assign st.x_hit     = x_q == {1'b0, addr_q};
	assign st.nx_null   = nx == NIL;
	assign st.key_hit   = key_rdata == key_q;
	assign st.cnt_full  = cnt_q == FULL;
	assign st.init_last = x_q == PW'(NODES - 1);
	assign st.in_group  = in_group_q;
	assign st.out_free  = !out_valid_q || !out_stall;

	assign out_valid    = out_valid_q;
	assign start_addr   = start_q;
	assign read_value   = rval_q;
	assign found        = found_q;
	assign is_free      = free_q;
	assign free_count   = count_q;
	assign out_of_space = oos_q;

endmodule

[rtl/fla_ctrl.sv]
// Controller of the free list node allocator: one-hot state machine that
// sequences clearing pass, allocation, list walks and result hand-off. Uses fla_pkg.
module fla_ctrl import fla_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  func,
	input  fla_status_t st,
	output fla_cmd_t    cmd
);

	typedef enum logic [11:0] {
		S_INIT      = 12'b000000000001,
		S_IDLE      = 12'b000000000010,
		S_ALOC      = 12'b000000000100,
		S_ALOC_WR   = 12'b000000001000,
		S_ALOC_LINK = 12'b000000010000,
		S_MEM_LOOK  = 12'b000000100000,
		S_MEM_STEP  = 12'b000001000000,
		S_CH_LOOK   = 12'b000010000000,
		S_CH_STEP   = 12'b000100000000,
		S_KEY_LOOK  = 12'b001000000000,
		S_KEY_CHK   = 12'b010000000000,
		S_DONE      = 12'b100000000000
	} fla_state_t;

	fla_state_t state_q, state_d;
	logic [2:0] op_q, op_d;
	logic       link_q, link_d;

	assign in_stall = state_q != S_IDLE;

	always_comb begin
		state_d = state_q;
		op_d    = op_q;
		link_d  = link_q;
		cmd     = '0;
		unique case (state_q)
			S_INIT: begin
				cmd.link_we   = 1'b1;
				cmd.link_wsel = LW_INIT;
				cmd.data_we   = 1'b1;
				cmd.data_zero = 1'b1;
				cmd.xsel      = X_INC;
				if (st.init_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					op_d       = func;
					unique case (func)
						FN_ALLOC: state_d = S_ALOC;
						FN_FREE, FN_TEST: begin
							cmd.xsel = X_HEAD;
							cmd.csel = C_ZERO;
							state_d  = S_MEM_LOOK;
						end
						FN_WRITE, FN_READ: begin
							cmd.xsel = X_ADDR;
							cmd.csel = C_ZERO;
							state_d  = S_KEY_LOOK;
						end
						default: state_d = S_DONE;
					endcase
				end
			end
			S_ALOC: begin
				if (st.head_null) begin
					cmd.set_oos = 1'b1;
					state_d     = S_DONE;
				end else begin
					cmd.link_rd_head = 1'b1;
					state_d          = S_ALOC_WR;
				end
			end
			S_ALOC_WR: begin
				cmd.alloc_take = 1'b1;
				cmd.key_we     = 1'b1;
				cmd.link_we    = 1'b1;
				cmd.link_wsel  = LW_NIL;
				cmd.xsel       = X_HEAD;
				link_d         = st.in_group;
				state_d        = S_ALOC_LINK;
			end
			S_ALOC_LINK: begin
				cmd.link_we   = link_q;
				cmd.link_wsel = LW_TAIL;
				cmd.set_tail  = 1'b1;
				state_d       = S_DONE;
			end
			S_MEM_LOOK: begin
				priority if (!st.addr_ok) begin
					state_d = S_DONE;
				end else if (st.x_null || st.cnt_full) begin
					if (op_q == FN_TEST) begin
						state_d = S_DONE;
					end else begin
						cmd.xsel = X_ADDR;
						cmd.csel = C_ONE;
						state_d  = S_CH_LOOK;
					end
				end else if (st.x_hit) begin
					cmd.set_free = op_q == FN_TEST;
					state_d      = S_DONE;
				end else begin
					state_d = S_MEM_STEP;
				end
			end
			S_MEM_STEP: begin
				cmd.xsel = X_NEXT;
				cmd.csel = C_INC;
				state_d  = S_MEM_LOOK;
			end
			S_CH_LOOK: begin
				state_d = S_CH_STEP;
			end
			S_CH_STEP: begin
				priority if (st.nx_null) begin
					cmd.link_we   = 1'b1;
					cmd.link_wsel = LW_SPLICE;
					cmd.splice    = 1'b1;
					state_d       = S_DONE;
				end else if (st.cnt_full) begin
					state_d = S_DONE;
				end else begin
					cmd.xsel = X_NEXT;
					cmd.csel = C_INC;
					state_d  = S_CH_LOOK;
				end
			end
			S_KEY_LOOK: begin
				if (st.x_null || st.cnt_full) begin
					state_d = S_DONE;
				end else begin
					state_d = S_KEY_CHK;
				end
			end
			S_KEY_CHK: begin
				if (st.key_hit) begin
					cmd.set_found = 1'b1;
					cmd.data_we   = op_q == FN_WRITE;
					cmd.set_rval  = op_q == FN_READ;
					state_d       = S_DONE;
				end else begin
					cmd.xsel = X_NEXT;
					cmd.csel = C_INC;
					state_d  = S_KEY_LOOK;
				end
			end
			S_DONE: begin
				if (st.out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_INIT;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
			op_q    <= FN_ALLOC;
			link_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			link_q  <= link_d;
		end
	end

endmodule

[rtl/fla_checker.sv]
// Port-level checker of the free list node allocator, bound to the top level.
// Uses free_list_node_allocator_assert.svh.
`include "free_list_node_allocator_assert.svh"

module fla_checker #(
	parameter int NODES = 64,
	parameter int KEY_BITS = 8,
	parameter int DATA_BITS = 32,
	localparam int AW = $clog2(NODES),
	localparam int CW = $clog2(NODES + 1)
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic [2:0]                  func,
	input logic [AW-1:0]               addr,
	input logic [KEY_BITS-1:0]         key,
	input logic signed [DATA_BITS-1:0] value,
	input logic                        last,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic [AW-1:0]               start_addr,
	input logic signed [DATA_BITS-1:0] read_value,
	input logic                        found,
	input logic                        is_free,
	input logic [CW-1:0]               free_count,
	input logic                        out_of_space
);

	// one item in work: an accepted word stalls the input next cycle
	`FLA_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

	// a word reports at most one of match, free and out of space
	`FLA_ASSERT_NOW(a_flags_exclusive, out_valid, $countones({found, is_free, out_of_space}) <= 1)

	// data only comes back with a match, a start only without an error
	`FLA_ASSERT_NOW(a_quiet_fields, out_valid && !found,
		read_value == '0 && (!out_of_space || start_addr == '0))

	// hold a stalled result word
	`FLA_ASSERT_NEXT(a_out_hold, out_valid && out_stall,
		out_valid && $stable(free_count) && $stable(read_value) && $stable(start_addr))

endmodule

bind free_list_node_allocator fla_checker #(
	.NODES     (NODES),
	.KEY_BITS  (KEY_BITS),
	.DATA_BITS (DATA_BITS)
) u_fla_checker (.*);
